>>> rtl/bbc_pkg.sv
// Package for the boot information blob checker.
// Holds the shared types, field offsets and protocol constants; no dependencies.
package bbc_pkg;

    localparam logic [31:0] BLOB_SIGNATURE = 32'h0000_0FFA;
    localparam logic [31:0] HDR_BYTES      = 32'd32;
    localparam logic [31:0] DESC_BYTES     = 32'd32;
    localparam logic [31:0] VALUE_MAX_BYTES = 32'd8;
    localparam logic [14:0] VERSION_MAJOR  = 15'd1;

    localparam int ARR_END_W = 38;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDR = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUF_LIMIT = 8'd1;

    localparam logic [2:0] WORD_SIGNATURE = 3'd0;
    localparam logic [2:0] WORD_VERSION   = 3'd1;
    localparam logic [2:0] WORD_SIZE      = 3'd2;
    localparam logic [2:0] WORD_DESC_SIZE = 3'd3;
    localparam logic [2:0] WORD_COUNT     = 3'd4;
    localparam logic [2:0] WORD_OFFSET    = 3'd5;
    localparam logic [2:0] WORD_RSV0      = 3'd6;
    localparam logic [2:0] WORD_RSV1      = 3'd7;

    localparam logic [4:0] OFF_TYPE = 5'd16;
    localparam logic [4:0] OFF_RSV  = 5'd17;
    localparam logic [4:0] OFF_SIZE = 5'd20;
    localparam logic [4:0] OFF_CONT = 5'd24;
    localparam logic [4:0] OFF_LAST = 5'd31;

    localparam logic [1:0] NAME_FMT_STRING = 2'd0;
    localparam logic [1:0] CONT_FMT_ADDR   = 2'd0;
    localparam logic [1:0] CONT_FMT_VALUE  = 2'd1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [QPTR_W:0] QUEUE_FULL = QUEUE_DEPTH[QPTR_W:0];

    typedef enum logic [1:0] {
        K_SKIP,
        K_SMALL,
        K_HDR,
        K_ENT
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_LAYOUT = 3'd1,
        ST_SIG    = 3'd2,
        ST_VER    = 3'd3,
        ST_RSV    = 3'd4,
        ST_DESC   = 3'd5
    } t_status;

    typedef struct packed {
        t_kind      kind;
        logic [4:0] off;
        logic [7:0] data;
        logic       last;
    } t_item;

    typedef struct packed {
        logic [63:0] base;
        logic [31:0] limit;
    } t_cfg;

    typedef struct packed {
        t_status     status;
        logic [31:0] version_word;
        logic [31:0] stated_size;
        logic [31:0] entry_count;
        logic [31:0] entry_offset;
    } t_result;

endpackage

>>> rtl/bbc_front.sv
// Front end of the blob checker: accepts bytes, tracks the byte position and
// tags each byte as header, descriptor, small-buffer or ignored. Uses bbc_pkg.
module bbc_front
    import bbc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  logic       i_q_full,
    output logic       o_push,
    output t_item      o_item
);

    logic [31:0]          r_pos, n_pos;
    logic [31:0]          r_w4, n_w4;
    logic [31:0]          r_w5, n_w5;
    logic [ARR_END_W-1:0] r_array_end;
    logic [4:0]           w_ent_off;

    assign o_push    = i_valid && !i_q_full;
    assign w_ent_off = r_pos[4:0] - r_w5[4:0];

    always_comb begin
        o_item.data = i_data_byte;
        o_item.last = i_last_byte;
        o_item.off  = 5'd0;
        o_item.kind = K_SKIP;
        priority if (r_pos == 32'd0 && i_cfg.limit < HDR_BYTES) begin
            o_item.kind = K_SMALL;
        end else if (r_pos < HDR_BYTES) begin
            o_item.kind = K_HDR;
            o_item.off  = r_pos[4:0];
        end else if (r_pos >= r_w5 && {6'd0, r_pos} < r_array_end) begin
            o_item.kind = K_ENT;
            o_item.off  = w_ent_off;
        end else begin
            o_item.kind = K_SKIP;
        end
    end

    always_comb begin
        n_pos = r_pos;
        n_w4  = r_w4;
        n_w5  = r_w5;
        if (o_push) begin
            if (i_last_byte) begin
                n_pos = 32'd0;
                n_w4  = 32'd0;
                n_w5  = 32'd0;
            end else begin
                if (r_pos != 32'hFFFF_FFFF) begin
                    n_pos = r_pos + 32'd1;
                end
                if (o_item.kind == K_HDR && r_pos[4:2] == WORD_COUNT) begin
                    n_w4[{r_pos[1:0], 3'b000} +: 8] = i_data_byte;
                end
                if (o_item.kind == K_HDR && r_pos[4:2] == WORD_OFFSET) begin
                    n_w5[{r_pos[1:0], 3'b000} +: 8] = i_data_byte;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= 32'd0;
            r_w4        <= 32'd0;
            r_w5        <= 32'd0;
            r_array_end <= '0;
        end else begin
            r_pos       <= n_pos;
            r_w4        <= n_w4;
            r_w5        <= n_w5;
            r_array_end <= {6'd0, r_w5} + {1'b0, r_w4, 5'd0};
        end
    end

endmodule

>>> rtl/bbc_queue.sv
// Short queue of tagged bytes between the front end and the back end.
// Uses the item type and depth from bbc_pkg.
module bbc_queue
    import bbc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_item o_item
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_full  = r_count == QUEUE_FULL;
    assign o_empty = r_count == '0;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/bbc_back.sv
// Back end of the blob checker: assembles the header and descriptor fields,
// runs the header and descriptor checks and holds the result. Uses bbc_pkg.
module bbc_back
    import bbc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_empty,
    input  t_item   i_item,
    output logic    o_pop,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_result o_result
);

    logic [31:0]          r_hw [8];
    logic [31:0]          n_hw [8];
    logic [31:0]          w_hw_upd [8];
    logic [ARR_END_W-1:0] r_array_end;
    logic [63:0]          r_blob_end;
    logic [31:0]          r_ent_pos, n_ent_pos;
    logic                 r_name_zero, n_name_zero;
    logic [7:0]           r_etype, n_etype;
    logic [7:0]           r_eres, n_eres;
    logic [15:0]          r_eflags, n_eflags;
    logic [31:0]          r_esize, n_esize;
    logic [63:0]          r_econt, n_econt;
    logic                 r_verdict, n_verdict;
    logic                 r_out_valid;
    t_result              r_result;

    logic        w_ready;
    logic        w_emit;
    t_status     w_st;
    t_status     w_hdr_st;
    t_status     w_ent_st;
    logic [63:0] w_cont;
    logic [63:0] w_room;
    logic [1:0]  w_name_fmt;
    logic [1:0]  w_cont_fmt;

    assign w_ready     = !r_out_valid || !i_out_stall;
    assign o_pop       = !i_empty && w_ready;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    always_comb begin
        w_hw_upd = r_hw;
        if (o_pop && !r_verdict && i_item.kind == K_HDR) begin
            w_hw_upd[i_item.off[4:2]][{i_item.off[1:0], 3'b000} +: 8] = i_item.data;
        end
    end

    always_comb begin
        w_hdr_st = ST_OK;
        priority if (w_hw_upd[WORD_SIGNATURE] != BLOB_SIGNATURE) begin
            w_hdr_st = ST_SIG;
        end else if (w_hw_upd[WORD_VERSION][31] ||
                     w_hw_upd[WORD_VERSION][30:16] != VERSION_MAJOR) begin
            w_hdr_st = ST_VER;
        end else if (w_hw_upd[WORD_RSV0] != 32'd0 || w_hw_upd[WORD_RSV1] != 32'd0) begin
            w_hdr_st = ST_RSV;
        end else if (w_hw_upd[WORD_DESC_SIZE] != DESC_BYTES ||
                     w_hw_upd[WORD_OFFSET] < HDR_BYTES ||
                     w_hw_upd[WORD_OFFSET][2:0] != 3'd0 ||
                     w_hw_upd[WORD_SIZE] < HDR_BYTES ||
                     w_hw_upd[WORD_SIZE] > i_cfg.limit ||
                     r_array_end > {6'd0, w_hw_upd[WORD_SIZE]}) begin
            w_hdr_st = ST_LAYOUT;
        end else begin
            w_hdr_st = ST_OK;
        end
    end

    assign w_cont     = {i_item.data, r_econt[55:0]};
    assign w_room     = r_blob_end - w_cont;
    assign w_name_fmt = r_eflags[1:0];
    assign w_cont_fmt = r_eflags[3:2];

    always_comb begin
        w_ent_st = ST_OK;
        priority if (r_eres != 8'd0) begin
            w_ent_st = ST_RSV;
        end else if (r_eflags[15:4] != 12'd0 || w_name_fmt > 2'd1 || w_cont_fmt > 2'd1) begin
            w_ent_st = ST_DESC;
        end else if (w_name_fmt == NAME_FMT_STRING && !r_name_zero) begin
            w_ent_st = ST_DESC;
        end else if (!r_etype[7] && r_etype > 8'd1) begin
            w_ent_st = ST_DESC;
        end else if (w_cont_fmt == CONT_FMT_VALUE &&
                     (r_esize == 32'd0 || r_esize > VALUE_MAX_BYTES)) begin
            w_ent_st = ST_DESC;
        end else if (w_cont_fmt == CONT_FMT_ADDR &&
                     (w_cont < i_cfg.base || w_cont > r_blob_end ||
                      {32'd0, r_esize} > w_room)) begin
            w_ent_st = ST_LAYOUT;
        end else begin
            w_ent_st = ST_OK;
        end
    end

    always_comb begin
        n_hw        = w_hw_upd;
        n_ent_pos   = r_ent_pos;
        n_name_zero = r_name_zero;
        n_etype     = r_etype;
        n_eres      = r_eres;
        n_eflags    = r_eflags;
        n_esize     = r_esize;
        n_econt     = r_econt;
        n_verdict   = r_verdict;
        w_emit      = 1'b0;
        w_st        = ST_LAYOUT;
        if (o_pop) begin
            if (!r_verdict) begin
                unique case (i_item.kind)
                    K_SMALL: begin
                        w_emit    = 1'b1;
                        w_st      = ST_LAYOUT;
                        n_verdict = 1'b1;
                    end
                    K_HDR: begin
                        if (i_item.off == OFF_LAST &&
                            (w_hdr_st != ST_OK || w_hw_upd[WORD_COUNT] == 32'd0)) begin
                            w_emit    = 1'b1;
                            w_st      = w_hdr_st;
                            n_verdict = 1'b1;
                        end
                    end
                    K_ENT: begin
                        priority if (i_item.off < OFF_TYPE) begin
                            if (i_item.data == 8'd0) begin
                                n_name_zero = 1'b1;
                            end
                        end else if (i_item.off == OFF_TYPE) begin
                            n_etype = i_item.data;
                        end else if (i_item.off == OFF_RSV) begin
                            n_eres = i_item.data;
                        end else if (i_item.off < OFF_SIZE) begin
                            n_eflags[{i_item.off[0], 3'b000} +: 8] = i_item.data;
                        end else if (i_item.off < OFF_CONT) begin
                            n_esize[{i_item.off[1:0], 3'b000} +: 8] = i_item.data;
                        end else begin
                            n_econt[{i_item.off[2:0], 3'b000} +: 8] = i_item.data;
                        end
                        if (i_item.off == OFF_LAST) begin
                            n_name_zero = 1'b0;
                            n_etype     = 8'd0;
                            n_eres      = 8'd0;
                            n_eflags    = 16'd0;
                            n_esize     = 32'd0;
                            n_econt     = 64'd0;
                            n_ent_pos   = r_ent_pos + 32'd1;
                            if (w_ent_st != ST_OK || n_ent_pos == r_hw[WORD_COUNT]) begin
                                w_emit    = 1'b1;
                                w_st      = w_ent_st;
                                n_verdict = 1'b1;
                            end
                        end
                    end
                    K_SKIP: begin
                    end
                endcase
            end
            if (i_item.last) begin
                if (!n_verdict) begin
                    w_emit = 1'b1;
                    w_st   = ST_LAYOUT;
                end
                n_hw        = '{default: '0};
                n_ent_pos   = 32'd0;
                n_name_zero = 1'b0;
                n_etype     = 8'd0;
                n_eres      = 8'd0;
                n_eflags    = 16'd0;
                n_esize     = 32'd0;
                n_econt     = 64'd0;
                n_verdict   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hw        <= '{default: '0};
            r_array_end <= '0;
            r_blob_end  <= 64'd0;
            r_ent_pos   <= 32'd0;
            r_name_zero <= 1'b0;
            r_etype     <= 8'd0;
            r_eres      <= 8'd0;
            r_eflags    <= 16'd0;
            r_esize     <= 32'd0;
            r_econt     <= 64'd0;
            r_verdict   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_hw        <= n_hw;
            r_array_end <= {6'd0, r_hw[WORD_OFFSET]} + {1'b0, r_hw[WORD_COUNT], 5'd0};
            r_blob_end  <= i_cfg.base + {32'd0, r_hw[WORD_SIZE]};
            r_ent_pos   <= n_ent_pos;
            r_name_zero <= n_name_zero;
            r_etype     <= n_etype;
            r_eres      <= n_eres;
            r_eflags    <= n_eflags;
            r_esize     <= n_esize;
            r_econt     <= n_econt;
            r_verdict   <= n_verdict;
            if (o_pop && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_emit) begin
            r_result.status       <= w_st;
            r_result.version_word <= w_hw_upd[WORD_VERSION];
            r_result.stated_size  <= w_hw_upd[WORD_SIZE];
            r_result.entry_count  <= w_hw_upd[WORD_COUNT];
            r_result.entry_offset <= w_hw_upd[WORD_OFFSET];
        end
    end

endmodule

>>> rtl/boot_info_blob_checker_unit.sv
// Top level of the boot information blob checker.
// Holds the configuration registers and joins bbc_front, bbc_queue and bbc_back.
//
//   Channel  Direction  Handshake                   Payload
//   input    in         i_in_valid / o_in_stall     i_data_byte, i_last_byte
//   result   out        o_out_valid / i_out_stall   o_status and four header words
//   config   in         i_cfg_wr_en                 i_cfg_index, i_cfg_wr_data
//
// One byte transaction is taken per cycle while o_in_stall is low; the byte that
// decides a result passes through the queue, then the result register holds it.
// Reset is synchronous and clears the configuration and the blob state, but not
// the result fields or queue storage. The input stalls only when the four-entry
// queue is full, which happens when the result register is held by a stalled output.
module boot_info_blob_checker_unit
    import bbc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_wr_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [2:0]           o_status,
    output logic [31:0]          o_version_word,
    output logic [31:0]          o_stated_size,
    output logic [31:0]          o_entry_count,
    output logic [31:0]          o_entry_offset
);

    t_cfg    r_cfg;
    logic    w_push;
    logic    w_pop;
    logic    w_q_full;
    logic    w_q_empty;
    t_item   w_front_item;
    t_item   w_q_item;
    t_result w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_BASE_ADDR: r_cfg.base  <= i_cfg_wr_data;
                CFG_BUF_LIMIT: r_cfg.limit <= i_cfg_wr_data[31:0];
                default: begin
                end
            endcase
        end
    end

    bbc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_in_valid),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_item      (w_front_item)
    );

    bbc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_item  (w_q_item)
    );

    bbc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_empty     (w_q_empty),
        .i_item      (w_q_item),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (w_result)
    );

    assign o_in_stall     = w_q_full;
    assign o_status       = w_result.status;
    assign o_version_word = w_result.version_word;
    assign o_stated_size  = w_result.stated_size;
    assign o_entry_count  = w_result.entry_count;
    assign o_entry_offset = w_result.entry_offset;

`ifndef SYNTHESIS
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status <= ST_DESC)
        else $error("Result status code out of range.");

    a_ok_version: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_OK) |->
            (!o_version_word[31] && o_version_word[30:16] == VERSION_MAJOR))
        else $error("Passing result carries a bad version word.");

    a_ok_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_OK) |->
            (o_entry_offset[2:0] == 3'd0 && o_entry_offset >= HDR_BYTES &&
             o_stated_size >= HDR_BYTES))
        else $error("Passing result carries a bad layout.");

    a_queue_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_full && w_q_empty))
        else $error("Queue reports full and empty at once.");
`endif

endmodule
